// ----- src/text_console_cursor_scroll_macros.svh -----
// assertion helpers for the text console block
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH

// implication checked on every rising edge outside reset
`define TCCS_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define TCCS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- src/tccs_pkg.sv -----
`default_nettype none

package tccs_pkg;

  localparam logic [7:0]  NewlineCode = 8'd10;
  localparam logic [7:0]  SpaceCode   = 8'd32;
  localparam logic [7:0]  AttrReset   = 8'd7;
  localparam logic [15:0] BlankCell   = {AttrReset, SpaceCode};
  localparam logic [15:0] ZeroCell    = 16'h0000;

  localparam logic KindPut  = 1'b0;
  localparam logic KindRead = 1'b1;

  // sequencer to address unit
  typedef struct packed {
    logic step;       // advance the sweep counter, wrapping after the last cell
    logic sel_sweep;  // adder forms counter plus one row instead of cursor address
  } au_ctrl_t;

  // address unit back to sequencer
  typedef struct packed {
    logic last;  // counter sits on the last cell
    logic copy;  // counter is below the last row, so a source row exists
  } au_stat_t;

endpackage

`default_nettype wire

// ----- src/tccs_ram.sv -----
`default_nettype none

module tccs_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/tccs_addr_unit.sv -----
`default_nettype none

module tccs_addr_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire tccs_pkg::au_ctrl_t               ctrl_i,
  input  wire logic [$clog2(ROWS*COLUMNS)-1:0]  row_base_i,
  input  wire logic [$clog2(COLUMNS)-1:0]       col_i,
  output logic      [$clog2(ROWS*COLUMNS)-1:0]  sum_o,
  output logic      [$clog2(ROWS*COLUMNS)-1:0]  cnt_o,
  output tccs_pkg::au_stat_t                    stat_o
);

  localparam int AW = $clog2(ROWS*COLUMNS);
  localparam logic [AW-1:0] ColsA    = AW'(COLUMNS);
  localparam logic [AW-1:0] LastCell = AW'(ROWS*COLUMNS - 1);
  localparam logic [AW-1:0] LastBase = AW'((ROWS - 1) * COLUMNS);

  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] op_a, op_b;

  // the one adder: cursor address, or source cell of a row copy
  always_comb begin
    op_a  = ctrl_i.sel_sweep ? cnt_q : row_base_i;
    op_b  = ctrl_i.sel_sweep ? ColsA : AW'(col_i);
    sum_o = op_a + op_b;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.step) begin
      cnt_d = (cnt_q == LastCell) ? '0 : cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o       = cnt_q;
  assign stat_o.last = (cnt_q == LastCell);
  assign stat_o.copy = (cnt_q < LastBase);

endmodule

`default_nettype wire

// ----- src/text_console_cursor_scroll.sv -----
`default_nettype none

// Text console over a ROWS x COLUMNS screen of 16-bit cells, attribute in the
// high byte and character in the low byte. A put word writes its character at
// the cursor with the current attribute and advances the cursor, wrapping at
// the last column; the newline code only moves the cursor to the start of the
// next row. Moving past the last row scrolls the screen up one row, zeroes the
// bottom row and flags scrolled in the result. A read word returns one cell
// (zero when off screen). Every word gives exactly one result word, which sits
// in an output register, so the next word may be taken while it waits.
// A put that scrolls sweeps the whole screen through the cell memory (one read
// and one write port), one cell a cycle. After reset the screen is filled with
// blanks (space, attribute 7) by a clearing pass during which no word is
// accepted; the attribute register may be written at any time the block is
// idle, including during that pass, and only affects cells written afterwards.
module text_console_cursor_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // attribute register
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  text_attribute_i,
  // input words
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [4:0]  read_row_i,
  input  wire logic [6:0]  read_column_i,
  // result words
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [15:0] cell_value_o,
  output logic      [4:0]  cursor_row_o,
  output logic      [6:0]  cursor_column_o,
  output logic             scrolled_o
);

`include "text_console_cursor_scroll_macros.svh"

  localparam int AW     = $clog2(ROWS*COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW_EXT = (RW > 5) ? RW : 5;
  localparam int CW_EXT = (CW > 7) ? CW : 7;

  localparam logic [AW-1:0] ColsA   = AW'(COLUMNS);
  localparam logic [RW-1:0] RowLast = RW'(ROWS - 1);
  localparam logic [CW-1:0] ColLast = CW'(COLUMNS - 1);
  localparam logic [7:0]    RowsL   = 8'(ROWS);
  localparam logic [8:0]    ColsL   = 9'(COLUMNS);

  // sequencer states
  localparam logic [1:0] S_CLEAR = 2'd0;  // blanking pass after reset
  localparam logic [1:0] S_IDLE  = 2'd1;  // waiting for a word
  localparam logic [1:0] S_SWEEP = 2'd2;  // scroll: copy rows up, zero bottom row
  localparam logic [1:0] S_RESP  = 2'd3;  // hand the result to the output register

  logic [1:0] state_q, state_d;

  // cursor
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] row_base_q, row_base_d;  // row_q * COLUMNS, kept incrementally

  logic [7:0] attr_q;

  // pending result
  logic res_rd_q, res_rd_d;
  logic res_scr_q, res_scr_d;

  // delayed write stage of the scroll sweep
  logic          wr_pend_q, wr_pend_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  logic          wr_zero_q, wr_zero_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_cell_q;
  logic [4:0]  out_row_q;
  logic [6:0]  out_col_q;
  logic        out_scr_q;

  tccs_pkg::au_ctrl_t au_ctrl;
  tccs_pkg::au_stat_t au_stat;
  logic [AW-1:0]      au_sum;
  logic [AW-1:0]      au_cnt;

  // memory ports
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata, mem_rdata;

  logic          in_fire, out_load;
  logic          is_put, is_newline, advance, scroll;
  logic          rd_hit;
  logic [AW-1:0] rd_addr;

  logic [RW_EXT-1:0] row_ext;
  logic [CW_EXT-1:0] col_ext;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_load    = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  // decode of the incoming word
  assign is_put     = (kind_i == tccs_pkg::KindPut);
  assign is_newline = (char_code_i == tccs_pkg::NewlineCode);
  assign advance    = is_newline || (col_q == ColLast);
  assign scroll     = advance && (row_q == RowLast);
  assign rd_hit     = ({3'b000, read_row_i} < RowsL) && ({2'b00, read_column_i} < ColsL);
  // only used when on screen, so the narrowing casts lose nothing
  assign rd_addr    = AW'(AW'(read_row_i) * ColsA + AW'(read_column_i));

  tccs_addr_unit #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_addr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (au_ctrl),
    .row_base_i (row_base_q),
    .col_i      (col_q),
    .sum_o      (au_sum),
    .cnt_o      (au_cnt),
    .stat_o     (au_stat)
  );

  tccs_ram #(
    .Width (16),
    .Depth (ROWS*COLUMNS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // sequencer and cursor
  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    row_base_d = row_base_q;
    res_rd_d   = res_rd_q;
    res_scr_d  = res_scr_q;
    wr_pend_d  = 1'b0;
    wr_addr_d  = wr_addr_q;
    wr_zero_d  = wr_zero_q;
    au_ctrl    = '0;

    unique case (state_q)
      S_CLEAR: begin
        au_ctrl.step = 1'b1;
        if (au_stat.last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (is_put) begin
            res_rd_d  = 1'b0;
            res_scr_d = scroll;
            if (advance) begin
              col_d = '0;
              // on the last row the base already points at the bottom row
              if (!scroll) begin
                row_d      = row_q + RW'(1);
                row_base_d = row_base_q + ColsA;
              end
            end else begin
              col_d = col_q + CW'(1);
            end
            state_d = scroll ? S_SWEEP : S_RESP;
          end else begin
            res_rd_d  = rd_hit;
            res_scr_d = 1'b0;
            state_d   = S_RESP;
          end
        end
      end
      S_SWEEP: begin
        // read cell+COLUMNS now, write it one row up next cycle, or zero the bottom row
        au_ctrl.step      = 1'b1;
        au_ctrl.sel_sweep = 1'b1;
        wr_pend_d         = 1'b1;
        wr_addr_d         = au_cnt;
        wr_zero_d         = !au_stat.copy;
        if (au_stat.last) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // memory port selection, at most one writer active in any cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = au_sum;
    mem_wdata = {attr_q, char_code_i};
    priority if (wr_pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_q;
      mem_wdata = wr_zero_q ? tccs_pkg::ZeroCell : mem_rdata;
    end else if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = au_cnt;
      mem_wdata = tccs_pkg::BlankCell;
    end else if (in_fire && is_put && !is_newline) begin
      mem_we = 1'b1;
    end else begin
      mem_we = 1'b0;
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = au_sum;
    if (state_q == S_SWEEP) begin
      mem_re = au_stat.copy;
    end else if (in_fire && !is_put && rd_hit) begin
      mem_re    = 1'b1;
      mem_raddr = rd_addr;
    end
  end

  // output register
  assign row_ext = RW_EXT'(row_q);
  assign col_ext = CW_EXT'(col_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cell_q <= res_rd_q ? mem_rdata : tccs_pkg::ZeroCell;
      out_row_q  <= row_ext[4:0];
      out_col_q  <= col_ext[6:0];
      out_scr_q  <= res_scr_q;
    end
    wr_addr_q <= wr_addr_d;
    wr_zero_q <= wr_zero_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      row_q       <= '0;
      col_q       <= '0;
      row_base_q  <= '0;
      attr_q      <= tccs_pkg::AttrReset;
      res_rd_q    <= 1'b0;
      res_scr_q   <= 1'b0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      row_base_q  <= row_base_d;
      res_rd_q    <= res_rd_d;
      res_scr_q   <= res_scr_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        attr_q <= text_attribute_i;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cell_value_o    = out_cell_q;
  assign cursor_row_o    = out_row_q;
  assign cursor_column_o = out_col_q;
  assign scrolled_o      = out_scr_q;

  // row base always tracks the cursor row
  `TCCS_ASSERT_IMP(a_row_base, state_q != S_CLEAR,
    row_base_q == AW'(AW'(row_q) * ColsA), "row base out of step with cursor row")
  // cursor never leaves the screen
  `TCCS_ASSERT_IMP(a_cursor_range, 1'b1,
    (row_q <= RowLast) && (col_q <= ColLast), "cursor off screen")
  // a put that runs off the bottom starts the sweep
  `TCCS_ASSERT_NEXT(a_scroll_sweep, in_fire && is_put && scroll,
    state_q == S_SWEEP, "scroll did not start the sweep")
  // the last copied cell is written before a new word can arrive
  `TCCS_ASSERT_IMP(a_no_write_clash, in_fire,
    !wr_pend_q, "sweep write still pending at a new word")
  // a scroll result always reports the bottom row
  `TCCS_ASSERT_IMP(a_scroll_row, out_load && res_scr_q,
    row_q == RowLast, "scrolled result not on the last row")

endmodule

`default_nettype wire

// ----- test/text_console_cursor_scroll_test.sv -----
`default_nettype none

module text_console_cursor_scroll_test;

  localparam int Columns       = 80;
  localparam int Rows          = 25;
  // the limit outlasts a scroll sweep, the clearing pass and the long hold-off
  localparam int WatchdogLimit = 12000;
  localparam int HoldOffCycles = 300;
  localparam int DrainCycles   = 50;

  // one result word as the block should present it
  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  row;
    logic [6:0]  column;
    logic        scrolled;
  } console_result_t;

  // shadow screen, cursor and attribute, plus the queue of results still owed
  class console_scoreboard;
    logic [15:0]     screen [Rows][Columns];
    int unsigned     row_pos;
    int unsigned     col_pos;
    logic [7:0]      attribute;
    console_result_t pending [$];
    int unsigned     errors;
    int unsigned     words;
    int unsigned     results;
    int unsigned     scrolls;
    int unsigned     off_screen_reads;

    function new();
      row_pos          = 0;
      col_pos          = 0;
      attribute        = tccs_pkg::AttrReset;
      errors           = 0;
      words            = 0;
      results          = 0;
      scrolls          = 0;
      off_screen_reads = 0;
      foreach (screen[r, c]) screen[r][c] = tccs_pkg::BlankCell;
    endfunction

    function void set_attribute(logic [7:0] value);
      attribute = value;
    endfunction

    // cursor down one row, scrolling the screen when it falls off the bottom
    function logic advance_row();
      row_pos++;
      if (row_pos < Rows) return 1'b0;
      for (int r = 0; r < Rows - 1; r++)
        for (int c = 0; c < Columns; c++) screen[r][c] = screen[r + 1][c];
      for (int c = 0; c < Columns; c++) screen[Rows - 1][c] = tccs_pkg::ZeroCell;
      row_pos = Rows - 1;
      scrolls++;
      return 1'b1;
    endfunction

    function void note_word(logic kind, logic [7:0] code, logic [4:0] rrow,
                            logic [6:0] rcol);
      console_result_t predicted;
      predicted = '0;
      if (kind == tccs_pkg::KindRead) begin
        if (rrow < Rows && rcol < Columns) predicted.cell_value = screen[rrow][rcol];
        else off_screen_reads++;
      end else if (code == tccs_pkg::NewlineCode) begin
        predicted.scrolled = advance_row();
        col_pos = 0;
      end else begin
        screen[row_pos][col_pos] = {attribute, code};
        col_pos++;
        if (col_pos >= Columns) begin
          col_pos = 0;
          predicted.scrolled = advance_row();
        end
      end
      predicted.row    = row_pos[4:0];
      predicted.column = col_pos[6:0];
      pending.push_back(predicted);
      words++;
    endfunction

    function void check_result(console_result_t got);
      console_result_t want;
      results++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %h", $time, got);
        return;
      end
      want = pending.pop_front();
      if (got.cell_value !== want.cell_value) begin
        errors++;
        $display("%0t: cell_value expected %h actual %h", $time, want.cell_value,
                 got.cell_value);
      end
      if (got.row !== want.row) begin
        errors++;
        $display("%0t: cursor_row expected %0d actual %0d", $time, want.row, got.row);
      end
      if (got.column !== want.column) begin
        errors++;
        $display("%0t: cursor_column expected %0d actual %0d", $time, want.column,
                 got.column);
      end
      if (got.scrolled !== want.scrolled) begin
        errors++;
        $display("%0t: scrolled expected %b actual %b", $time, want.scrolled,
                 got.scrolled);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  text_attribute_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        kind_i;
  logic [7:0]  char_code_i;
  logic [4:0]  read_row_i;
  logic [6:0]  read_column_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] cell_value_o;
  logic [4:0]  cursor_row_o;
  logic [6:0]  cursor_column_o;
  logic        scrolled_o;

  console_scoreboard sb;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_request;
  int unsigned attr_writes;
  int unsigned quiet_cycles;

  text_console_cursor_scroll u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .text_attribute_i (text_attribute_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .char_code_i      (char_code_i),
    .read_row_i       (read_row_i),
    .read_column_i    (read_column_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cell_value_o     (cell_value_o),
    .cursor_row_o     (cursor_row_o),
    .cursor_column_o  (cursor_column_o),
    .scrolled_o       (scrolled_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // any accepted word on any channel counts as progress; long silence is a hang
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 ||
        (in_valid_i && in_ready_o === 1'b1) ||
        (out_valid_o === 1'b1 && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no word accepted for %0d cycles, %0d results still owed", $time,
               WatchdogLimit, sb.pending.size());
      $display("text_console_cursor_scroll: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: check every accepted word, then pick ready for the next edge
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i)
        sb.check_result({cell_value_o, cursor_row_o, cursor_column_o, scrolled_o});
      if (hold_request) begin
        // long hold-off so the output register and the input side back up
        hold_request = 1'b0;
        hold_left    = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one word, idling beforehand at the current rate, and hold it until taken
  task automatic send_word(input logic kind, input logic [7:0] code,
                           input logic [4:0] rrow, input logic [6:0] rcol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    char_code_i   <= code;
    read_row_i    <= rrow;
    read_column_i <= rcol;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_word(kind, code, rrow, rcol);
  endtask

  // unused fields carry random bits so the block must ignore them
  task automatic put_char(input logic [7:0] code);
    send_word(tccs_pkg::KindPut, code, 5'($urandom_range(31)), 7'($urandom_range(127)));
  endtask

  task automatic read_cell(input logic [4:0] rrow, input logic [6:0] rcol);
    send_word(tccs_pkg::KindRead, 8'($urandom_range(255)), rrow, rcol);
  endtask

  // reads lean on the bottom row and the cursor row, where scrolls leave traces
  task automatic read_somewhere();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30)
      read_cell(5'(Rows - 1), 7'($urandom_range(Columns - 1)));
    else if (pick < 55)
      read_cell(5'(sb.row_pos), 7'($urandom_range(Columns - 1)));
    else if (pick < 85)
      read_cell(5'($urandom_range(Rows - 1)), 7'($urandom_range(Columns - 1)));
    else if (pick < 92)
      read_cell(5'($urandom_range(31, Rows)), 7'($urandom_range(127)));
    else
      read_cell(5'($urandom_range(31)), 7'($urandom_range(127, Columns)));
  endtask

  task automatic write_attribute(input logic [7:0] value);
    cfg_valid_i      <= 1'b1;
    text_attribute_i <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    sb.set_attribute(value);
    attr_writes++;
  endtask

  // block is idle once every owed result has been taken
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // mostly text lines ended by newline, with reads in between, plus some noise
  task automatic run_random(input int count);
    int target;
    int pick;
    int len;
    target = sb.words + count;
    while (sb.words < target) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        pick = $urandom_range(99);
        if (pick < 80) len = $urandom_range(8);
        else if (pick < 90) len = $urandom_range(Columns + 5, Columns - 5);
        else len = 0;
        repeat (len) begin
          put_char(8'($urandom_range(255)));
          if ($urandom_range(99) < 15) read_somewhere();
        end
        if ($urandom_range(99) < 90) put_char(tccs_pkg::NewlineCode);
      end else if (pick < 85) begin
        repeat ($urandom_range(4, 1)) read_somewhere();
      end else begin
        send_word(1'($urandom_range(1)), 8'($urandom_range(255)),
                  5'($urandom_range(31)), 7'($urandom_range(127)));
      end
    end
  endtask

  initial begin : stimulus
    sb               = new();
    attr_writes      = 0;
    hold_request     = 1'b0;
    send_idle_pct    = 37;
    recv_idle_pct    = 50;
    quiet_cycles     <= 0;
    rst_ni           <= 1'b0;
    cfg_valid_i      <= 1'b0;
    text_attribute_i <= 8'h00;
    in_valid_i       <= 1'b0;
    kind_i           <= tccs_pkg::KindPut;
    char_code_i      <= 8'h00;
    read_row_i       <= 5'd0;
    read_column_i    <= 7'd0;
    out_ready_i      <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero attribute, allowed during the clearing pass
    write_attribute(8'h00);

    // corners read back as blanks, off-screen reads give zero
    read_cell(5'd0, 7'd0);
    read_cell(5'(Rows - 1), 7'(Columns - 1));
    read_cell(5'(Rows), 7'd0);
    read_cell(5'd0, 7'(Columns));
    read_cell(5'd31, 7'd127);
    // lowest and highest character codes, then newline writes nothing
    put_char(8'h00);
    put_char(8'hFF);
    read_cell(5'd0, 7'd0);
    read_cell(5'd0, 7'd1);
    put_char(tccs_pkg::NewlineCode);
    put_char(8'h41);
    drain();

    // attribute change only touches cells written afterwards
    write_attribute(8'hFF);
    put_char(8'h7E);
    read_cell(5'd1, 7'd1);
    read_cell(5'd1, 7'd0);
    // walk the cursor down towards the bottom so scrolls come early
    repeat (10) put_char(tccs_pkg::NewlineCode);
    read_cell(5'(Rows - 1), 7'd0);
    drain();

    write_attribute(8'($urandom_range(255)));
    run_random(210);
    drain();

    send_idle_pct = 50;
    recv_idle_pct = 37;
    write_attribute(8'($urandom_range(255)));
    run_random(210);
    drain();

    // no idling; one long receiver hold-off while words keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_attribute(tccs_pkg::AttrReset);
    hold_request = 1'b1;
    run_random(210);
    drain();

    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending.size() != 0) sb.errors++;
    $display("covered %0d words (%0d off-screen reads), %0d results, %0d scrolls,",
             sb.words, sb.off_screen_reads, sb.results, sb.scrolls);
    $display("%0d attribute writes, three idling patterns and one long output stall",
             attr_writes);
    if (sb.errors == 0) begin
      $display("text_console_cursor_scroll: match");
    end else begin
      $display("text_console_cursor_scroll: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+src
src/tccs_pkg.sv
src/tccs_ram.sv
src/tccs_addr_unit.sv
src/text_console_cursor_scroll.sv
test/text_console_cursor_scroll_test.sv
